>>> rtl/core/woau_pkg.sv
// Package: payload types, codes and decode helpers for the write operand address unit
package woau_pkg;

	localparam int NUM_REGS = 32;
	localparam int REG_IW   = $clog2(NUM_REGS);

	localparam logic [1:0] CMD_DECODE = 2'd0;
	localparam logic [1:0] CMD_RDATA  = 2'd1;
	localparam logic [1:0] CMD_LOAD   = 2'd2;

	localparam logic [2:0] ACT_REG   = 3'd0;
	localparam logic [2:0] ACT_MEMWR = 3'd1;
	localparam logic [2:0] ACT_PTRRD = 3'd2;
	localparam logic [2:0] ACT_ERR   = 3'd3;
	localparam logic [2:0] ACT_LOAD  = 3'd4;

	localparam logic [2:0] FLT_T1S7   = 3'd0;
	localparam logic [2:0] FLT_G7RSV  = 3'd1;
	localparam logic [2:0] FLT_G7ABIT = 3'd2;
	localparam logic [2:0] FLT_G7ARSV = 3'd3;
	localparam logic [2:0] FLT_IMM    = 3'd4;
	localparam logic [2:0] FLT_QIMM   = 3'd5;

	localparam logic [1:0] SZ_WORD = 2'd2;

	// Address base sources
	localparam logic [1:0] BASE_REG = 2'd0;
	localparam logic [1:0] BASE_PC  = 2'd1;
	localparam logic [1:0] BASE_ABS = 2'd2;

	// Register side effects
	localparam logic [1:0] UPD_NONE    = 2'd0;
	localparam logic [1:0] UPD_POSTINC = 2'd1;
	localparam logic [1:0] UPD_PREDEC  = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic        mode_select;
		logic [7:0]  mode_byte;
		logic [63:0] ext_bytes;
		logic [31:0] pc_value;
		logic [1:0]  size_code;
		logic [31:0] store_value;
		logic [31:0] read_data;
		logic [4:0]  load_index;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] target;
		logic [31:0] data_out;
		logic [1:0]  width_code;
		logic [3:0]  spec_length;
		logic [2:0]  fault_code;
	} out_item_t;

	// Classified operation handed from front to back
	typedef enum logic [2:0] {
		OP_MEMWR, OP_PTRRD, OP_MERGE, OP_FAULT, OP_RDATA, OP_LOAD, OP_NONE
	} op_t;

	// base_sel: register, PC or absolute word
	typedef struct packed {
		op_t         op;
		logic [1:0]  base_sel;
		logic [31:0] abs_word;
		logic [31:0] pc;
		logic [4:0]  base_reg;
		logic [4:0]  idx_reg;
		logic        use_idx;
		logic        idx_scaled;
		logic [31:0] disp1;
		logic [31:0] disp2;
		logic [1:0]  upd;      // none, post-increment or pre-decrement
		logic [1:0]  size;
		logic [31:0] value;
		logic [31:0] read_data;
		logic [3:0]  len;
		logic [2:0]  fault;
		logic [4:0]  load_index;
	} work_t;

	function automatic logic [31:0] size_mask(input logic [1:0] sz);
		case (sz)
			2'd0:    size_mask = 32'h0000_00FF;
			2'd1:    size_mask = 32'h0000_FFFF;
			default: size_mask = 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic logic [7:0] ext_byte(input logic [63:0] e, input logic [2:0] k);
		ext_byte = e[k*8 +: 8];
	endfunction

	function automatic logic [31:0] ext_word(input logic [63:0] e, input logic [2:0] k);
		ext_word = {ext_byte(e, k + 3'd3), ext_byte(e, k + 3'd2),
			ext_byte(e, k + 3'd1), ext_byte(e, k)};
	endfunction

	function automatic logic [31:0] disp(input logic [63:0] e, input logic [1:0] kind,
		input logic [2:0] k);
		logic [15:0] h;
		h = {ext_byte(e, k + 3'd1), ext_byte(e, k)};
		case (kind)
			2'd0:    disp = {{24{h[7]}}, h[7:0]};
			2'd1:    disp = {{16{h[15]}}, h};
			default: disp = ext_word(e, k);
		endcase
	endfunction

	function automatic logic [2:0] disp_len(input logic [1:0] kind);
		case (kind)
			2'd0:    disp_len = 3'd1;
			2'd1:    disp_len = 3'd2;
			default: disp_len = 3'd4;
		endcase
	endfunction

endpackage

>>> rtl/core/write_operand_address_unit.sv
// Top level: write operand address unit, front decode and back execute
// An item is registered in the front end; its result is then queued for output.
// Throughput: one item per cycle when not stalled; one register-file pass sets it.
// Front holds one item, result queue two; full rises only when both stall.
// Reset clears the register file, pending write and both queues at once.
module write_operand_address_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  woau_pkg::in_item_t  in_item,
	input  logic                push,
	output logic                full,
	output woau_pkg::out_item_t out_item,
	output logic                empty,
	input  logic                pop
);

	woau_pkg::work_t work;
	logic            work_valid;
	logic            work_take;

	woau_front u_front (
		.clk, .arst_n, .in_item, .push, .full,
		.work, .work_valid, .work_take
	);

	woau_back u_back (
		.clk, .arst_n, .work, .work_valid, .work_take,
		.out_item, .empty, .pop
	);

endmodule

>>> rtl/core/woau_front.sv
// Front end: input queue stage that classifies specifiers into work records
module woau_front (
	input  logic              clk,
	input  logic              arst_n,
	input  woau_pkg::in_item_t in_item,
	input  logic              push,
	output logic              full,
	output woau_pkg::work_t   work,
	output logic              work_valid,
	input  logic              work_take
);

	woau_pkg::work_t w;
	logic            valid_q;
	woau_pkg::work_t work_q;
	logic [1:0]      sz;
	logic [2:0]      mode;
	logic [4:0]      r;
	logic [7:0]      b0;
	logic [2:0]      sel;
	logic [3:0]      t;
	logic [63:0]     e;
	logic [2:0]      n;

	// Decode one specifier into base, displacements and operation
	always_comb begin
		e    = in_item.ext_bytes;
		sz   = (in_item.size_code == 2'd3) ? woau_pkg::SZ_WORD : in_item.size_code;
		mode = in_item.mode_byte[7:5];
		r    = in_item.mode_byte[4:0];
		b0   = e[7:0];
		sel  = b0[7:5];
		t    = b0[3:0];
		n    = 3'd0;
		w            = '0;
		w.op         = woau_pkg::OP_NONE;
		w.base_sel   = woau_pkg::BASE_REG;
		w.upd        = woau_pkg::UPD_NONE;
		w.size       = sz;
		w.value      = in_item.store_value;
		w.read_data  = in_item.read_data;
		w.load_index = in_item.load_index;
		w.base_reg   = r;
		w.idx_reg    = r;
		w.abs_word   = woau_pkg::ext_word(e, 3'd0);
		w.pc         = in_item.pc_value;
		case (in_item.cmd)
			woau_pkg::CMD_RDATA: w.op = woau_pkg::OP_RDATA;
			woau_pkg::CMD_LOAD:  w.op = woau_pkg::OP_LOAD;
			woau_pkg::CMD_DECODE: begin
				if (!in_item.mode_select) begin
					if (mode <= 3'd2) begin
						w.op = woau_pkg::OP_MEMWR;
						w.disp1 = woau_pkg::disp(e, mode[1:0], 3'd0);
						w.len = {1'b0, 3'd1 + woau_pkg::disp_len(mode[1:0])};
					end else if (mode == 3'd3) begin
						w.op = woau_pkg::OP_MEMWR;
						w.len = 4'd1;
					end else if (mode <= 3'd6) begin
						w.op = woau_pkg::OP_PTRRD;
						w.disp1 = woau_pkg::disp(e, 2'(mode - 3'd4), 3'd0);
						w.len = {1'b0, 3'd1 + woau_pkg::disp_len(2'(mode - 3'd4))};
					end else begin
						w.base_sel = woau_pkg::BASE_PC;
						if (r < 5'd16) begin
							w.op = woau_pkg::OP_FAULT; w.fault = woau_pkg::FLT_QIMM;
						end else if (r <= 5'd18) begin
							w.op = woau_pkg::OP_MEMWR;
							w.disp1 = woau_pkg::disp(e, r[1:0], 3'd0);
							w.len = {1'b0, 3'd1 + woau_pkg::disp_len(r[1:0])};
						end else if (r == 5'd19) begin
							w.op = woau_pkg::OP_MEMWR; w.base_sel = woau_pkg::BASE_ABS;
							w.len = 4'd5;
						end else if (r == 5'd20) begin
							w.op = woau_pkg::OP_FAULT; w.fault = woau_pkg::FLT_IMM;
						end else if (r <= 5'd23 || r == 5'd31) begin
							w.op = woau_pkg::OP_FAULT; w.fault = woau_pkg::FLT_G7RSV;
						end else if (r <= 5'd26) begin
							w.op = woau_pkg::OP_PTRRD;
							w.disp1 = woau_pkg::disp(e, 2'(r - 5'd24), 3'd0);
							w.len = {1'b0, 3'd1 + woau_pkg::disp_len(2'(r - 5'd24))};
						end else if (r == 5'd27) begin
							w.op = woau_pkg::OP_PTRRD; w.base_sel = woau_pkg::BASE_ABS;
							w.len = 4'd5;
						end else begin
							n = woau_pkg::disp_len(2'(r - 5'd28));
							w.op = woau_pkg::OP_PTRRD;
							w.disp1 = woau_pkg::disp(e, 2'(r - 5'd28), 3'd0);
							w.disp2 = woau_pkg::disp(e, 2'(r - 5'd28), n);
							w.len = 4'd1 + {n, 1'b0};
						end
					end
				end else begin
					case (mode)
						3'd0, 3'd1, 3'd2: begin
							n = woau_pkg::disp_len(mode[1:0]);
							w.op = woau_pkg::OP_PTRRD;
							w.disp1 = woau_pkg::disp(e, mode[1:0], 3'd0);
							w.disp2 = woau_pkg::disp(e, mode[1:0], n);
							w.len = 4'd1 + {n, 1'b0};
						end
						3'd3: begin
							w.op = woau_pkg::OP_MERGE; w.len = 4'd1;
						end
						3'd4: begin
							w.op = woau_pkg::OP_MEMWR; w.len = 4'd1;
							w.upd = woau_pkg::UPD_POSTINC;
						end
						3'd5: begin
							w.op = woau_pkg::OP_MEMWR; w.len = 4'd1;
							w.upd = woau_pkg::UPD_PREDEC;
						end
						3'd6: begin
							w.base_reg = b0[4:0];
							w.use_idx = 1'b1;
							w.idx_scaled = 1'b1;
							if (sel <= 3'd2) begin
								w.op = woau_pkg::OP_MEMWR;
								w.disp1 = woau_pkg::disp(e, sel[1:0], 3'd1);
								w.len = {1'b0, 3'd2 + woau_pkg::disp_len(sel[1:0])};
							end else if (sel == 3'd3) begin
								w.op = woau_pkg::OP_MEMWR; w.len = 4'd2;
							end else if (sel <= 3'd6) begin
								w.op = woau_pkg::OP_PTRRD;
								w.disp1 = woau_pkg::disp(e, 2'(sel - 3'd4), 3'd1);
								w.len = {1'b0, 3'd2 + woau_pkg::disp_len(2'(sel - 3'd4))};
							end else if (!b0[4]) begin
								w.op = woau_pkg::OP_FAULT; w.fault = woau_pkg::FLT_G7ABIT;
							end else begin
								w.base_sel = woau_pkg::BASE_PC;
								w.abs_word = woau_pkg::ext_word(e, 3'd1);
								if (t <= 4'd2) begin
									w.op = woau_pkg::OP_MEMWR;
									w.disp1 = woau_pkg::disp(e, t[1:0], 3'd1);
									w.len = {1'b0, 3'd2 + woau_pkg::disp_len(t[1:0])};
								end else if (t == 4'd3) begin
									w.op = woau_pkg::OP_MEMWR; w.base_sel = woau_pkg::BASE_ABS;
									w.len = 4'd6;
								end else if (t >= 4'd8 && t <= 4'd10) begin
									w.op = woau_pkg::OP_PTRRD;
									w.disp1 = woau_pkg::disp(e, t[1:0], 3'd1);
									w.len = {1'b0, 3'd2 + woau_pkg::disp_len(t[1:0])};
								end else if (t == 4'd11) begin
									w.op = woau_pkg::OP_PTRRD; w.base_sel = woau_pkg::BASE_ABS;
									w.idx_scaled = 1'b0; w.len = 4'd6;
								end else begin
									w.op = woau_pkg::OP_FAULT; w.fault = woau_pkg::FLT_G7ARSV;
								end
							end
						end
						default: begin
							w.op = woau_pkg::OP_FAULT; w.fault = woau_pkg::FLT_T1S7;
						end
					endcase
				end
			end
			default: w.op = woau_pkg::OP_NONE;
		endcase
	end

	// Hold one classified item; refill as the back end takes it
	assign full       = valid_q && !work_take;
	assign work       = work_q;
	assign work_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!full) begin
			valid_q <= push && (w.op != woau_pkg::OP_NONE);
		end
	end

	always_ff @(posedge clk) begin
		if (!full) begin
			work_q <= w;
		end
	end

endmodule

>>> rtl/core/woau_back.sv
// Back end: register file, pending pointer write and result output queue
module woau_back (
	input  logic               clk,
	input  logic               arst_n,
	input  woau_pkg::work_t    work,
	input  logic               work_valid,
	output logic               work_take,
	output woau_pkg::out_item_t out_item,
	output logic               empty,
	input  logic               pop
);

	logic [31:0]      regs_q [woau_pkg::NUM_REGS];
	logic             pend_q;
	logic [31:0]      pend_off_q;
	logic [1:0]       pend_size_q;
	logic [31:0]      pend_val_q;
	logic [3:0]       pend_len_q;
	logic [1:0]       occ_q;
	woau_pkg::out_item_t fifo_q [2];
	logic             rd_q;
	logic             wr_q;
	woau_pkg::out_item_t res;
	logic             res_valid;
	logic [31:0]      breg;
	logic [31:0]      ireg;
	logic [31:0]      base;
	logic [31:0]      idx;
	logic [31:0]      addr;
	logic [31:0]      msk;
	logic [31:0]      step;
	logic [31:0]      mval;
	logic             do_push;

	assign work_take = work_valid && (occ_q != 2'd2);
	assign do_push   = work_take && res_valid;

	// Carry out one work record
	always_comb begin
		breg = regs_q[work.base_reg];
		ireg = regs_q[work.idx_reg];
		msk  = woau_pkg::size_mask(work.size);
		step = 32'd1 << work.size;
		case (work.base_sel)
			woau_pkg::BASE_PC:  base = work.pc;
			woau_pkg::BASE_ABS: base = work.abs_word;
			default:            base = breg;
		endcase
		idx = work.use_idx ? (work.idx_scaled ? (ireg << work.size) : ireg) : '0;
		mval = (breg & ~msk) | (work.value & msk);
		addr = base + work.disp1 + ((work.upd == woau_pkg::UPD_PREDEC) ? -step : 32'd0);
		res = '0;
		res_valid = 1'b1;
		case (work.op)
			woau_pkg::OP_MEMWR: begin
				res.action = woau_pkg::ACT_MEMWR;
				res.target = addr + idx;
				res.data_out = work.value & msk;
				res.width_code = work.size;
				res.spec_length = work.len;
			end
			woau_pkg::OP_PTRRD: begin
				res.action = woau_pkg::ACT_PTRRD;
				res.target = addr;
				res.width_code = woau_pkg::SZ_WORD;
				res.spec_length = work.len;
			end
			woau_pkg::OP_MERGE: begin
				res.action = woau_pkg::ACT_REG;
				res.target = {27'd0, work.base_reg};
				res.data_out = mval;
				res.width_code = work.size;
				res.spec_length = work.len;
			end
			woau_pkg::OP_FAULT: begin
				res.action = woau_pkg::ACT_ERR;
				res.fault_code = work.fault;
			end
			woau_pkg::OP_RDATA: begin
				res_valid = pend_q;
				res.action = woau_pkg::ACT_MEMWR;
				res.target = work.read_data + pend_off_q;
				res.data_out = pend_val_q;
				res.width_code = pend_size_q;
				res.spec_length = pend_len_q;
			end
			woau_pkg::OP_LOAD: begin
				res.action = woau_pkg::ACT_LOAD;
				res.target = {27'd0, work.load_index};
				res.data_out = work.value;
				res.width_code = woau_pkg::SZ_WORD;
			end
			default: res_valid = 1'b0;
		endcase
	end

	// Update register file and pending write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < woau_pkg::NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
			pend_q      <= 1'b0;
			pend_off_q  <= '0;
			pend_size_q <= '0;
			pend_val_q  <= '0;
			pend_len_q  <= '0;
		end else if (work_take) begin
			case (work.op)
				woau_pkg::OP_MERGE: regs_q[work.base_reg] <= mval;
				woau_pkg::OP_LOAD:  regs_q[work.load_index] <= work.value;
				woau_pkg::OP_MEMWR: begin
					pend_q <= 1'b0;
					if (work.upd == woau_pkg::UPD_POSTINC) regs_q[work.base_reg] <= breg + step;
					else if (work.upd == woau_pkg::UPD_PREDEC) regs_q[work.base_reg] <= breg - step;
				end
				woau_pkg::OP_PTRRD: begin
					pend_q      <= 1'b1;
					pend_off_q  <= work.disp2 + idx;
					pend_size_q <= work.size;
					pend_val_q  <= work.value & msk;
					pend_len_q  <= work.len;
				end
				woau_pkg::OP_FAULT: pend_q <= 1'b0;
				woau_pkg::OP_RDATA: pend_q <= 1'b0;
				default: pend_q <= pend_q;
			endcase
			if (work.op == woau_pkg::OP_MERGE) pend_q <= 1'b0;
		end
	end

	// Two-entry result queue; transfer out on pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (pop && !empty) rd_q <= ~rd_q;
			occ_q <= occ_q + {1'b0, do_push} - {1'b0, pop && !empty};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) fifo_q[wr_q] <= res;
	end

	assign empty    = (occ_q == 2'd0);
	assign out_item = fifo_q[rd_q];

endmodule

>>> dv/write_operand_address_unit_tb.sv
// Testbench for the write operand address unit: directed and random specifiers, checked by prediction
`timescale 1ns / 1ps
module write_operand_address_unit_tb;

	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	woau_pkg::in_item_t in_item;
	logic push;
	logic full;
	woau_pkg::out_item_t out_item;
	logic empty;
	logic pop;

	write_operand_address_unit dut (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .push(push), .full(full),
		.out_item(out_item), .empty(empty), .pop(pop)
	);

	// Predictor state
	logic [31:0] regs_m [woau_pkg::NUM_REGS];
	logic        pend_m;
	logic [31:0] pend_off_m;
	logic [1:0]  pend_size_m;
	logic [31:0] pend_val_m;
	logic [3:0]  pend_len_m;

	woau_pkg::out_item_t expected_writes [$];
	int          error_count;
	int          result_count;
	int          item_count;
	int          cycle_count;
	int          burst_left;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Predictor helpers at block widths
	function automatic logic [31:0] mask_of(logic [1:0] sz);
		return sz == 2'd0 ? 32'hFF : (sz == 2'd1 ? 32'hFFFF : 32'hFFFF_FFFF);
	endfunction

	function automatic logic [7:0] byte_at(logic [63:0] e, int k);
		return e[(k & 7) * 8 +: 8];
	endfunction

	function automatic logic [31:0] word_at(logic [63:0] e, int k);
		return {byte_at(e, k + 3), byte_at(e, k + 2), byte_at(e, k + 1), byte_at(e, k)};
	endfunction

	function automatic logic [31:0] offset_at(logic [63:0] e, int kind, int k);
		logic [15:0] h;
		h = {byte_at(e, k + 1), byte_at(e, k)};
		if (kind == 0) return {{24{h[7]}}, h[7:0]};
		if (kind == 1) return {{16{h[15]}}, h};
		return word_at(e, k);
	endfunction

	function automatic int offset_len(int kind);
		return kind == 0 ? 1 : (kind == 1 ? 2 : 4);
	endfunction

	function automatic woau_pkg::out_item_t pack_result(logic [2:0] act, logic [31:0] tgt,
		logic [31:0] dat, logic [1:0] w, int len, logic [2:0] flt);
		woau_pkg::out_item_t r;
		r.action = act; r.target = tgt; r.data_out = dat;
		r.width_code = w; r.spec_length = len[3:0]; r.fault_code = flt;
		return r;
	endfunction

	// Work out the result of one accepted item; returns 0 when none
	function automatic bit predict_store(woau_pkg::in_item_t it, output woau_pkg::out_item_t res);
		logic [1:0]  sz;
		logic [31:0] val, msk, base, idx, nv;
		logic [63:0] e;
		logic [7:0]  b0;
		logic [4:0]  r;
		logic [2:0]  mode;
		int          ri, mi, sel, t, n;
		sz  = it.size_code == 2'd3 ? woau_pkg::SZ_WORD : it.size_code;
		msk = mask_of(sz);
		val = it.store_value & msk;
		e   = it.ext_bytes;
		r   = it.mode_byte[4:0];
		mode = it.mode_byte[7:5];
		ri  = int'(r);
		mi  = int'(mode);
		base = '0; idx = '0;
		res = '0;
		if (it.cmd == woau_pkg::CMD_RDATA) begin
			if (!pend_m) return 0;
			pend_m = 1'b0;
			res = pack_result(woau_pkg::ACT_MEMWR, it.read_data + pend_off_m, pend_val_m,
				pend_size_m, int'(pend_len_m), woau_pkg::FLT_T1S7);
			return 1;
		end
		if (it.cmd == woau_pkg::CMD_LOAD) begin
			regs_m[it.load_index] = it.store_value;
			res = pack_result(woau_pkg::ACT_LOAD, {27'd0, it.load_index}, it.store_value,
				woau_pkg::SZ_WORD, 0, woau_pkg::FLT_T1S7);
			return 1;
		end
		if (it.cmd != woau_pkg::CMD_DECODE) return 0;
		pend_m = 1'b0;
		// Address cases as (kind of result, base, deferred offset, length)
		begin : decode_blk
			bit   ptr;
			bit   flt;
			logic [2:0]  fc;
			logic [31:0] addr, off;
			int   len;
			ptr = 0; flt = 0; fc = woau_pkg::FLT_T1S7; addr = '0; off = '0; len = 0;
			if (!it.mode_select) begin
				if (mi <= 2) begin
					addr = regs_m[r] + offset_at(e, mi, 0); len = 1 + offset_len(mi);
				end else if (mi == 3) begin
					addr = regs_m[r]; len = 1;
				end else if (mi <= 6) begin
					ptr = 1; addr = regs_m[r] + offset_at(e, mi - 4, 0);
					len = 1 + offset_len(mi - 4);
				end else if (ri < 16) begin
					flt = 1; fc = woau_pkg::FLT_QIMM;
				end else if (ri <= 18) begin
					addr = it.pc_value + offset_at(e, ri - 16, 0); len = 1 + offset_len(ri - 16);
				end else if (ri == 19) begin
					addr = word_at(e, 0); len = 5;
				end else if (ri == 20) begin
					flt = 1; fc = woau_pkg::FLT_IMM;
				end else if (ri <= 23 || ri == 31) begin
					flt = 1; fc = woau_pkg::FLT_G7RSV;
				end else if (ri <= 26) begin
					ptr = 1; addr = it.pc_value + offset_at(e, ri - 24, 0);
					len = 1 + offset_len(ri - 24);
				end else if (ri == 27) begin
					ptr = 1; addr = word_at(e, 0); len = 5;
				end else begin
					n = offset_len(ri - 28);
					ptr = 1; addr = it.pc_value + offset_at(e, ri - 28, 0);
					off = offset_at(e, ri - 28, n); len = 1 + 2 * n;
				end
			end else begin
				case (mode)
					3'd0, 3'd1, 3'd2: begin
						n = offset_len(mi);
						ptr = 1; addr = regs_m[r] + offset_at(e, mi, 0);
						off = offset_at(e, mi, n); len = 1 + 2 * n;
					end
					3'd3: begin
						nv = (regs_m[r] & ~msk) | val;
						regs_m[r] = nv;
						res = pack_result(woau_pkg::ACT_REG, {27'd0, r}, nv, sz, 1,
							woau_pkg::FLT_T1S7);
						return 1;
					end
					3'd4: begin
						addr = regs_m[r]; len = 1;
						regs_m[r] = regs_m[r] + (32'd1 << sz);
					end
					3'd5: begin
						regs_m[r] = regs_m[r] - (32'd1 << sz);
						addr = regs_m[r]; len = 1;
					end
					3'd6: begin
						b0 = byte_at(e, 0);
						base = regs_m[b0[4:0]];
						sel = int'(b0[7:5]);
						idx = regs_m[r] << sz;
						if (sel <= 2) begin
							addr = base + offset_at(e, sel, 1) + idx; len = 2 + offset_len(sel);
						end else if (sel == 3) begin
							addr = base + idx; len = 2;
						end else if (sel <= 6) begin
							ptr = 1; addr = base + offset_at(e, sel - 4, 1); off = idx;
							len = 2 + offset_len(sel - 4);
						end else if (!b0[4]) begin
							flt = 1; fc = woau_pkg::FLT_G7ABIT;
						end else begin
							t = int'(b0[3:0]);
							if (t <= 2) begin
								addr = it.pc_value + offset_at(e, t, 1) + idx;
								len = 2 + offset_len(t);
							end else if (t == 3) begin
								addr = word_at(e, 1) + idx; len = 6;
							end else if (t >= 8 && t <= 10) begin
								ptr = 1; addr = it.pc_value + offset_at(e, t - 8, 1); off = idx;
								len = 2 + offset_len(t - 8);
							end else if (t == 11) begin
								// deferred absolute indexed: index unscaled
								ptr = 1; addr = word_at(e, 1); off = regs_m[r]; len = 6;
							end else begin
								flt = 1; fc = woau_pkg::FLT_G7ARSV;
							end
						end
					end
					default: begin
						flt = 1; fc = woau_pkg::FLT_T1S7;
					end
				endcase
			end
			if (flt)
				res = pack_result(woau_pkg::ACT_ERR, '0, '0, 2'd0, 0, fc);
			else if (ptr) begin
				pend_m = 1'b1; pend_off_m = off; pend_size_m = sz;
				pend_val_m = val; pend_len_m = len[3:0];
				res = pack_result(woau_pkg::ACT_PTRRD, addr, '0, woau_pkg::SZ_WORD, len,
					woau_pkg::FLT_T1S7);
			end else
				res = pack_result(woau_pkg::ACT_MEMWR, addr, val, sz, len, woau_pkg::FLT_T1S7);
		end
		return 1;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, result_count);
		error_count++;
	endtask

	// Cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver stall pattern: long free stretches, then random stalls
	always @(negedge clk) begin
		if (!arst_n) pop <= 1'b0;
		else if (cycle_count % 512 < 128) pop <= 1'b1;
		else pop <= ($urandom_range(0, 3) != 0);
	end

	// Check each transfer out against the oldest prediction
	always @(posedge clk) begin
		woau_pkg::out_item_t w;
		if (arst_n && pop && !empty) begin
			result_count++;
			if (expected_writes.size() == 0) begin
				report_mismatch("unexpected result, action", 32'(out_item.action), 32'd0);
			end else begin
				w = expected_writes.pop_front();
				if (out_item.action !== w.action)
					report_mismatch("action", 32'(out_item.action), 32'(w.action));
				if (out_item.target !== w.target)
					report_mismatch("target", out_item.target, w.target);
				if (out_item.data_out !== w.data_out)
					report_mismatch("data_out", out_item.data_out, w.data_out);
				if (out_item.width_code !== w.width_code)
					report_mismatch("width_code", 32'(out_item.width_code), 32'(w.width_code));
				if (out_item.spec_length !== w.spec_length)
					report_mismatch("spec_length", 32'(out_item.spec_length),
						32'(w.spec_length));
				if (out_item.fault_code !== w.fault_code)
					report_mismatch("fault_code", 32'(out_item.fault_code), 32'(w.fault_code));
			end
		end
	end

	// Send one item: bursts with random gaps, wait for the transfer
	task automatic send_item(woau_pkg::in_item_t it);
		woau_pkg::out_item_t res;
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 4);
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_item <= it;
		push <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		if (predict_store(it, res)) expected_writes.push_back(res);
		item_count++;
		@(negedge clk);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (expected_writes.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic woau_pkg::in_item_t random_item();
		woau_pkg::in_item_t it;
		it.cmd = 2'($urandom_range(0, 3));
		it.mode_select = 1'($urandom_range(0, 1));
		it.mode_byte = 8'($urandom_range(0, 255));
		it.ext_bytes = {$urandom, $urandom};
		it.pc_value = $urandom;
		it.size_code = 2'($urandom_range(0, 3));
		it.store_value = $urandom;
		it.read_data = $urandom;
		it.load_index = 5'($urandom_range(0, 31));
		return it;
	endfunction

	function automatic woau_pkg::in_item_t make_item(logic [1:0] c, logic m, logic [7:0] mb,
		logic [63:0] e, logic [1:0] sz);
		woau_pkg::in_item_t it;
		it = random_item();
		it.cmd = c; it.mode_select = m; it.mode_byte = mb; it.ext_bytes = e; it.size_code = sz;
		return it;
	endfunction

	task automatic test_directed();
		woau_pkg::in_item_t it;
		send_item(make_item(woau_pkg::CMD_LOAD, 1'b0, 8'h00, '1, 2'd2));
		send_item(make_item(woau_pkg::CMD_RDATA, 1'b0, 8'h00, '0, 2'd0)); // nothing pending
		send_item(make_item(2'd3, 1'b0, 8'hFF, '1, 2'd0));                // unused command
		send_item(make_item(woau_pkg::CMD_DECODE, 1'b0, 8'h1F, 64'h80, 2'd0));
		send_item(make_item(woau_pkg::CMD_DECODE, 1'b0, 8'h41, 64'hFFFF_FFFF, 2'd3));
		send_item(make_item(woau_pkg::CMD_DECODE, 1'b1, 8'h62, '0, 2'd1));
		send_item(make_item(woau_pkg::CMD_DECODE, 1'b1, 8'h83, '0, 2'd2));
		send_item(make_item(woau_pkg::CMD_DECODE, 1'b1, 8'hA3, '0, 2'd0));
		send_item(make_item(woau_pkg::CMD_DECODE, 1'b1, 8'hE0, '0, 2'd0));
		send_item(make_item(woau_pkg::CMD_DECODE, 1'b0, 8'hE0, '1, 2'd0));
		send_item(make_item(woau_pkg::CMD_DECODE, 1'b0, 8'hF4, '1, 2'd0));
		send_item(make_item(woau_pkg::CMD_DECODE, 1'b0, 8'hF6, '1, 2'd0));
		send_item(make_item(woau_pkg::CMD_DECODE, 1'b0, 8'hFF, '1, 2'd0));
		send_item(make_item(woau_pkg::CMD_DECODE, 1'b1, 8'hC1, 64'hE0, 2'd0));
		send_item(make_item(woau_pkg::CMD_DECODE, 1'b1, 8'hC1, 64'hFF, 2'd0));
		// deferred absolute indexed, then a load kept across pending, then its data
		send_item(make_item(woau_pkg::CMD_DECODE, 1'b1, 8'hC2, 64'h8765_4321_FB, 2'd1));
		send_item(make_item(woau_pkg::CMD_LOAD, 1'b0, 8'h00, '0, 2'd0));
		send_item(make_item(woau_pkg::CMD_RDATA, 1'b0, 8'h00, '0, 2'd0));
		// pending abandoned by a new decode
		send_item(make_item(woau_pkg::CMD_DECODE, 1'b0, 8'h9C, '1, 2'd2));
		send_item(make_item(woau_pkg::CMD_DECODE, 1'b1, 8'h60, '0, 2'd0));
		send_item(make_item(woau_pkg::CMD_RDATA, 1'b0, 8'h00, '0, 2'd0));
		it = make_item(woau_pkg::CMD_DECODE, 1'b1, 8'h20, 64'h7FFF_8000, 2'd0);
		send_item(it);
		it.cmd = woau_pkg::CMD_RDATA; it.read_data = '1;
		send_item(it);
	endtask

	// Mostly well-formed: loads, decodes and usually the data return after an indirect mode
	task automatic test_random(int count);
		woau_pkg::in_item_t it;
		int k;
		for (k = 0; k < count; k++) begin
			it = random_item();
			if ($urandom_range(0, 9) < 7) begin
				it.cmd = $urandom_range(0, 3) == 0 ? woau_pkg::CMD_LOAD : woau_pkg::CMD_DECODE;
				if (it.mode_byte[7:5] == 3'd6 && $urandom_range(0, 1) != 0)
					it.ext_bytes[4] = 1'b1;
			end
			send_item(it);
			if (pend_m && $urandom_range(0, 7) != 0) begin
				it = random_item();
				it.cmd = woau_pkg::CMD_RDATA;
				send_item(it);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		in_item = '0;
		item_count = 0; burst_left = 0;
		for (int i = 0; i < woau_pkg::NUM_REGS; i++) regs_m[i] = '0;
		pend_m = 1'b0; pend_off_m = '0; pend_size_m = '0; pend_val_m = '0; pend_len_m = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		drain(); // hold the sender until every result is back
		test_random(500);
		drain();
		$display("Run covered %0d items and %0d results over both mode tables", item_count,
			result_count);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> write_operand_address_unit.f
rtl/core/woau_pkg.sv
rtl/core/woau_front.sv
rtl/core/woau_back.sv
rtl/core/write_operand_address_unit.sv
dv/write_operand_address_unit_tb.sv
